// ===== design/rss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, widths and codes for the refresh source scheduler.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int QUEUE_DEPTH = 16;

  localparam int IDX_W  = $clog2(MAX_SOURCES);
  localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W       = 2;
  localparam int SLOT_W     = 4;
  localparam int PRIO_W     = 8;
  localparam int CODE_W     = 16;
  localparam int TIME_W     = 48;
  localparam int DELAY_W    = 24;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int ENTRY_W    = SLOT_W + CODE_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_UPDATE  = 2'd2,
    OP_REQUEST = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_PACKET = 2'd1,
    KIND_IDLE   = 2'd2,
    KIND_FULL   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DELAY = 1'b0,
    CFG_EXCL_PRIO = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_ADD_WRITE,
    DP_REMOVE,
    DP_EXCL_INIT,
    DP_PRIO_READ,
    DP_EXCL_CHECK,
    DP_RESULT_ACK,
    DP_RESULT_ADD,
    DP_QUEUE_PUSH,
    DP_SERVE_EXCL,
    DP_QUEUE_POP,
    DP_ENTRY_LATCH,
    DP_ENTRY_CHECK,
    DP_SCAN_INIT,
    DP_SCAN_READ
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   scan_check;
    logic   emit;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic excl_ok;
    logic queue_nonempty;
    logic entry_served;
    logic scan_hit;
    logic cnt_last;
    logic cnt_full;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/refresh_source_scheduler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// refresh_source_scheduler_core
// Picks the packet source for each track packet: exclusive source, urgent
// update queue, or a round-robin scan over stale slots.
// ----------------------------------------------------------------------------
// Update pushes to the queue; add/remove search every slot for the exclusive
// source; a request serves the exclusive source, else the queue, else a scan.
// One transaction at a time; the slot table is walked one slot at a time
// through its single registered read port.
// A result waits in the output register while the next transaction is taken.
// Asynchronous active-low reset clears control state; no clearing pass.
// ----------------------------------------------------------------------------
module refresh_source_scheduler_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [rss_pkg::OP_W-1:0]       opcode_i,
  input  wire logic [rss_pkg::SLOT_W-1:0]     slot_i,
  input  wire logic [rss_pkg::PRIO_W-1:0]     priority_req_i,
  input  wire logic [rss_pkg::CODE_W-1:0]     code_i,
  input  wire logic [rss_pkg::TIME_W-1:0]     current_time_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [rss_pkg::KIND_W-1:0]     kind_o,
  output logic      [rss_pkg::SLOT_W-1:0]     chosen_slot_o,
  output logic      [rss_pkg::CODE_W-1:0]     update_code_o,
  output logic                                became_excl_o
);

  rss_pkg::ctrl_cmd_t  cmd;
  rss_pkg::dp_status_t status;

  rss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .priority_req_i (priority_req_i),
    .code_i         (code_i),
    .current_time_i (current_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .chosen_slot_o  (chosen_slot_o),
    .update_code_o  (update_code_o),
    .became_excl_o  (became_excl_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule
`default_nettype wire

// ===== design/rss_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rss_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/rss_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rss_dp
// Scheduler datapath: configuration, slot table, update queue, exclusive
// search, stale scan and the output register.
// ----------------------------------------------------------------------------
module rss_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rss_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [rss_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic [rss_pkg::OP_W-1:0]            opcode_i,
  input  wire logic [rss_pkg::SLOT_W-1:0]          slot_i,
  input  wire logic [rss_pkg::PRIO_W-1:0]          priority_req_i,
  input  wire logic [rss_pkg::CODE_W-1:0]          code_i,
  input  wire logic [rss_pkg::TIME_W-1:0]          current_time_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [rss_pkg::KIND_W-1:0]          kind_o,
  output logic      [rss_pkg::SLOT_W-1:0]          chosen_slot_o,
  output logic      [rss_pkg::CODE_W-1:0]          update_code_o,
  output logic                                     became_excl_o,
  input  wire rss_pkg::ctrl_cmd_t                  cmd_i,
  output rss_pkg::dp_status_t                      status_o
);

  localparam int IW  = rss_pkg::IDX_W;
  localparam int CW  = rss_pkg::CNT_W;
  localparam int QIW = rss_pkg::QIDX_W;
  localparam int QCW = rss_pkg::QCNT_W;
  localparam int TW  = rss_pkg::TIME_W;
  localparam int SW  = rss_pkg::SLOT_W;
  localparam int DW  = rss_pkg::CODE_W;
  localparam int EW  = rss_pkg::ENTRY_W;
  localparam int PW  = rss_pkg::PRIO_W;

  logic [rss_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic [PW-1:0]               min_prio_q, min_prio_d;
  rss_pkg::op_e                op_q, op_d;
  logic [SW-1:0]               slot_q, slot_d;
  logic [PW-1:0]               prio_q, prio_d;
  logic [DW-1:0]               code_q, code_d;
  logic [TW-1:0]               now_q, now_d;
  logic [rss_pkg::MAX_SOURCES-1:0] valid_q, valid_d;
  logic [QIW-1:0]              head_q, head_d;
  logic [QCW-1:0]              count_q, count_d;
  logic [IW-1:0]               scan_q, scan_d;
  logic                        excl_valid_q, excl_valid_d;
  logic [IW-1:0]               excl_slot_q, excl_slot_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [PW-1:0]               best_q, best_d;
  logic [EW-1:0]               entry_q, entry_d;
  logic [IW-1:0]               cur_q, cur_d;
  rss_pkg::kind_e              res_kind_q, res_kind_d;
  logic [SW-1:0]               res_slot_q, res_slot_d;
  logic [DW-1:0]               res_code_q, res_code_d;
  logic                        res_excl_q, res_excl_d;
  logic                        out_valid_q, out_valid_d;
  rss_pkg::kind_e              out_kind_q, out_kind_d;
  logic [SW-1:0]               out_slot_q, out_slot_d;
  logic [DW-1:0]               out_code_q, out_code_d;
  logic                        out_excl_q, out_excl_d;

  logic           prio_we;
  logic [IW-1:0]  prio_waddr, prio_raddr;
  logic [PW-1:0]  prio_wdata, prio_rdata;
  logic           time_we;
  logic [IW-1:0]  time_waddr, time_raddr;
  logic [TW-1:0]  time_wdata, time_rdata;
  logic           queue_we;
  logic [QIW-1:0] queue_waddr, queue_raddr;
  logic [EW-1:0]  queue_wdata, queue_rdata;

  logic [IW-1:0]  slot_idx, cnt_idx, entry_idx, rd_entry_idx;
  logic           slot_in_range, entry_in_range;
  logic [SW-1:0]  entry_slot;
  logic [DW-1:0]  entry_code;
  logic [QCW:0]   tail_sum;
  logic [QIW-1:0] tail, head_next;
  logic [IW-1:0]  scan_next;
  logic [TW:0]    time_limit, now_ext;
  logic           recent, stale, entry_missing, entry_served, scan_hit, queue_full;

  assign slot_idx       = IW'(slot_q);
  assign slot_in_range  = int'(slot_q) < rss_pkg::MAX_SOURCES;
  assign cnt_idx        = cnt_q[IW-1:0];
  assign entry_slot     = entry_q[EW-1 -: SW];
  assign entry_code     = entry_q[DW-1:0];
  assign entry_idx      = IW'(entry_slot);
  assign entry_in_range = int'(entry_slot) < rss_pkg::MAX_SOURCES;
  assign rd_entry_idx   = IW'(queue_rdata[EW-1 -: SW]);

  assign tail_sum  = (QCW+1)'(head_q) + (QCW+1)'(count_q);
  assign tail      = (tail_sum >= (QCW+1)'(rss_pkg::QUEUE_DEPTH))
                   ? QIW'(tail_sum - (QCW+1)'(rss_pkg::QUEUE_DEPTH))
                   : QIW'(tail_sum);
  assign head_next = (head_q == QIW'(rss_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + QIW'(1);
  assign scan_next = (scan_q == IW'(rss_pkg::MAX_SOURCES - 1)) ? '0 : scan_q + IW'(1);
  assign queue_full = count_q >= QCW'(rss_pkg::QUEUE_DEPTH);

  assign time_limit = (TW+1)'(time_rdata) + (TW+1)'(delay_q);
  assign now_ext    = (TW+1)'(now_q);
  assign recent     = time_limit > now_ext;
  assign stale      = time_limit < now_ext;

  assign entry_missing = !(entry_in_range && valid_q[entry_idx]);
  assign entry_served  = !entry_missing && !recent;
  assign scan_hit      = valid_q[cur_q] && stale;

  always_comb begin
    prio_we     = 1'b0;
    prio_waddr  = slot_idx;
    prio_wdata  = prio_q;
    prio_raddr  = cnt_idx;
    time_we     = 1'b0;
    time_waddr  = slot_idx;
    time_wdata  = '0;
    time_raddr  = scan_q;
    queue_we    = 1'b0;
    queue_waddr = tail;
    queue_wdata = {slot_q, code_q};
    queue_raddr = head_q;

    delay_d      = delay_q;
    min_prio_d   = min_prio_q;
    op_d         = op_q;
    slot_d       = slot_q;
    prio_d       = prio_q;
    code_d       = code_q;
    now_d        = now_q;
    valid_d      = valid_q;
    head_d       = head_q;
    count_d      = count_q;
    scan_d       = scan_q;
    excl_valid_d = excl_valid_q;
    excl_slot_d  = excl_slot_q;
    cnt_d        = cnt_q;
    best_d       = best_q;
    entry_d      = entry_q;
    cur_d        = cur_q;
    res_kind_d   = res_kind_q;
    res_slot_d   = res_slot_q;
    res_code_d   = res_code_q;
    res_excl_d   = res_excl_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_kind_d   = out_kind_q;
    out_slot_d   = out_slot_q;
    out_code_d   = out_code_q;
    out_excl_d   = out_excl_q;

    if (cfg_we_i) begin
      unique case (rss_pkg::cfg_reg_e'(cfg_index_i))
        rss_pkg::CFG_MIN_DELAY: delay_d = cfg_data_i[rss_pkg::DELAY_W-1:0];
        rss_pkg::CFG_EXCL_PRIO: min_prio_d = cfg_data_i[PW-1:0];
      endcase
    end

    unique case (cmd_i.op)
      rss_pkg::DP_NOP: begin
      end
      rss_pkg::DP_CAPTURE: begin
        op_d   = rss_pkg::op_e'(opcode_i);
        slot_d = slot_i;
        prio_d = priority_req_i;
        code_d = code_i;
        now_d  = current_time_i;
      end
      rss_pkg::DP_ADD_WRITE: begin
        prio_we = slot_in_range;
        time_we = slot_in_range;
        if (slot_in_range) begin
          valid_d[slot_idx] = 1'b1;
        end
      end
      rss_pkg::DP_REMOVE: begin
        if (slot_in_range) begin
          valid_d[slot_idx] = 1'b0;
        end
      end
      rss_pkg::DP_EXCL_INIT: begin
        best_d       = min_prio_q;
        excl_valid_d = 1'b0;
        excl_slot_d  = '0;
        cnt_d        = '0;
      end
      rss_pkg::DP_PRIO_READ: begin
      end
      rss_pkg::DP_EXCL_CHECK: begin
        if (valid_q[cnt_idx] && (prio_rdata > best_q)) begin
          best_d       = prio_rdata;
          excl_valid_d = 1'b1;
          excl_slot_d  = cnt_idx;
        end
        cnt_d = cnt_q + CW'(1);
      end
      rss_pkg::DP_RESULT_ACK: begin
        res_kind_d = rss_pkg::KIND_ACK;
        res_slot_d = '0;
        res_code_d = '0;
        res_excl_d = 1'b0;
      end
      rss_pkg::DP_RESULT_ADD: begin
        res_kind_d = rss_pkg::KIND_ACK;
        res_slot_d = '0;
        res_code_d = '0;
        res_excl_d = slot_in_range && excl_valid_q && (excl_slot_q == slot_idx);
      end
      rss_pkg::DP_QUEUE_PUSH: begin
        res_slot_d = '0;
        res_code_d = '0;
        res_excl_d = 1'b0;
        if (queue_full) begin
          res_kind_d = rss_pkg::KIND_FULL;
        end else begin
          queue_we   = 1'b1;
          count_d    = count_q + QCW'(1);
          res_kind_d = rss_pkg::KIND_ACK;
        end
      end
      rss_pkg::DP_SERVE_EXCL: begin
        time_we    = 1'b1;
        time_waddr = excl_slot_q;
        time_wdata = now_q;
        res_kind_d = rss_pkg::KIND_PACKET;
        res_slot_d = SW'(excl_slot_q);
        res_code_d = '0;
        res_excl_d = 1'b0;
      end
      rss_pkg::DP_QUEUE_POP: begin
        head_d  = head_next;
        count_d = count_q - QCW'(1);
      end
      rss_pkg::DP_ENTRY_LATCH: begin
        entry_d    = queue_rdata;
        time_raddr = rd_entry_idx;
      end
      rss_pkg::DP_ENTRY_CHECK: begin
        if (!entry_missing) begin
          if (recent) begin
            // send back to the tail
            queue_we    = 1'b1;
            queue_wdata = entry_q;
            count_d     = count_q + QCW'(1);
          end else begin
            time_we    = 1'b1;
            time_waddr = entry_idx;
            time_wdata = now_q;
            res_kind_d = rss_pkg::KIND_PACKET;
            res_slot_d = entry_slot;
            res_code_d = entry_code;
            res_excl_d = 1'b0;
          end
        end
      end
      rss_pkg::DP_SCAN_INIT: begin
        cnt_d = '0;
      end
      rss_pkg::DP_SCAN_READ: begin
        cur_d  = scan_q;
        scan_d = scan_next;
        cnt_d  = cnt_q + CW'(1);
      end
    endcase

    if (cmd_i.scan_check) begin
      res_code_d = '0;
      res_excl_d = 1'b0;
      if (scan_hit) begin
        time_we    = 1'b1;
        time_waddr = cur_q;
        time_wdata = now_q;
        res_kind_d = rss_pkg::KIND_PACKET;
        res_slot_d = SW'(cur_q);
      end else begin
        res_kind_d = rss_pkg::KIND_IDLE;
        res_slot_d = '0;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = res_kind_q;
      out_slot_d  = res_slot_q;
      out_code_d  = res_code_q;
      out_excl_d  = res_excl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q      <= '0;
      min_prio_q   <= '1;
      valid_q      <= '0;
      head_q       <= '0;
      count_q      <= '0;
      scan_q       <= '0;
      excl_valid_q <= 1'b0;
      excl_slot_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      delay_q      <= delay_d;
      min_prio_q   <= min_prio_d;
      valid_q      <= valid_d;
      head_q       <= head_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      excl_valid_q <= excl_valid_d;
      excl_slot_q  <= excl_slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    slot_q     <= slot_d;
    prio_q     <= prio_d;
    code_q     <= code_d;
    now_q      <= now_d;
    cnt_q      <= cnt_d;
    best_q     <= best_d;
    entry_q    <= entry_d;
    cur_q      <= cur_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
    res_code_q <= res_code_d;
    res_excl_q <= res_excl_d;
    out_kind_q <= out_kind_d;
    out_slot_q <= out_slot_d;
    out_code_q <= out_code_d;
    out_excl_q <= out_excl_d;
  end

  rss_ram #(.WIDTH(PW), .DEPTH(rss_pkg::MAX_SOURCES)) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (prio_waddr),
    .wdata_i (prio_wdata),
    .raddr_i (prio_raddr),
    .rdata_o (prio_rdata)
  );

  rss_ram #(.WIDTH(TW), .DEPTH(rss_pkg::MAX_SOURCES)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (time_waddr),
    .wdata_i (time_wdata),
    .raddr_i (time_raddr),
    .rdata_o (time_rdata)
  );

  rss_ram #(.WIDTH(EW), .DEPTH(rss_pkg::QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (queue_we),
    .waddr_i (queue_waddr),
    .wdata_i (queue_wdata),
    .raddr_i (queue_raddr),
    .rdata_o (queue_rdata)
  );

  assign status_o.op             = op_q;
  assign status_o.excl_ok        = excl_valid_q && valid_q[excl_slot_q];
  assign status_o.queue_nonempty = count_q != '0;
  assign status_o.entry_served   = entry_served;
  assign status_o.scan_hit       = scan_hit;
  assign status_o.cnt_last       = cnt_q == CW'(rss_pkg::MAX_SOURCES - 1);
  assign status_o.cnt_full       = cnt_q == CW'(rss_pkg::MAX_SOURCES);
  assign status_o.out_busy       = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign chosen_slot_o = out_slot_q;
  assign update_code_o = out_code_q;
  assign became_excl_o = out_excl_q;

endmodule
`default_nettype wire

// ===== design/rss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rss_ctrl
// Scheduler sequencer: steps the datapath through each transaction.
// ----------------------------------------------------------------------------
module rss_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rss_pkg::dp_status_t status_i,
  output rss_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EXCL_INIT,
    S_EXCL_RD,
    S_EXCL_CHK,
    S_EXCL_RES,
    S_ENTRY,
    S_ENTRY_CHK,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o.op         = rss_pkg::DP_NOP;
    cmd_o.scan_check = 1'b0;
    cmd_o.emit       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rss_pkg::DP_CAPTURE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.op)
          rss_pkg::OP_ADD: begin
            cmd_o.op = rss_pkg::DP_ADD_WRITE;
            state_d  = S_EXCL_INIT;
          end
          rss_pkg::OP_REMOVE: begin
            cmd_o.op = rss_pkg::DP_REMOVE;
            state_d  = S_EXCL_INIT;
          end
          rss_pkg::OP_UPDATE: begin
            cmd_o.op = rss_pkg::DP_QUEUE_PUSH;
            state_d  = S_DONE;
          end
          rss_pkg::OP_REQUEST: begin
            priority if (status_i.excl_ok) begin
              cmd_o.op = rss_pkg::DP_SERVE_EXCL;
              state_d  = S_DONE;
            end else if (status_i.queue_nonempty) begin
              cmd_o.op = rss_pkg::DP_QUEUE_POP;
              state_d  = S_ENTRY;
            end else begin
              state_d = S_SCAN_INIT;
            end
          end
        endcase
      end
      S_EXCL_INIT: begin
        cmd_o.op = rss_pkg::DP_EXCL_INIT;
        state_d  = S_EXCL_RD;
      end
      S_EXCL_RD: begin
        cmd_o.op = rss_pkg::DP_PRIO_READ;
        state_d  = S_EXCL_CHK;
      end
      S_EXCL_CHK: begin
        cmd_o.op = rss_pkg::DP_EXCL_CHECK;
        state_d  = status_i.cnt_last ? S_EXCL_RES : S_EXCL_RD;
      end
      S_EXCL_RES: begin
        cmd_o.op = (status_i.op == rss_pkg::OP_ADD) ? rss_pkg::DP_RESULT_ADD
                                                    : rss_pkg::DP_RESULT_ACK;
        state_d  = S_DONE;
      end
      S_ENTRY: begin
        cmd_o.op = rss_pkg::DP_ENTRY_LATCH;
        state_d  = S_ENTRY_CHK;
      end
      S_ENTRY_CHK: begin
        cmd_o.op = rss_pkg::DP_ENTRY_CHECK;
        state_d  = status_i.entry_served ? S_DONE : S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        cmd_o.op = rss_pkg::DP_SCAN_INIT;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = rss_pkg::DP_SCAN_READ;
        state_d  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.scan_check = 1'b1;
        state_d = (status_i.scan_hit || status_i.cnt_full) ? S_DONE : S_SCAN_RD;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule
`default_nettype wire
